// ===== rtl/bmo_pkg.sv =====
package bmo_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd127;
  localparam int unsigned      WIDTH_RST     = 640;
  localparam int unsigned      HEIGHT_RST    = 480;

  localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

  localparam logic MODE_PIXEL = 1'b0;

  localparam int unsigned OFIFO_DEPTH = 8;

  // 3x3 window: [column][row], column 0 = left, row 2 = top
  typedef logic [2:0][2:0] win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // step of the window pipeline
  typedef struct packed {
    logic    valid;
    logic    emit;
    logic    last;
    border_t eb;
    border_t ob;
  } tick_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

  // Minimum (use_and) or maximum over the window, neighbors outside the frame skipped.
  function automatic logic win_reduce(input win_t win, input border_t bd, input logic use_and);
    logic acc;
    logic keep;
    acc = use_and;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        keep = !((c == 0 && bd.left) || (c == 2 && bd.right) ||
                 (r == 2 && bd.top) || (r == 0 && bd.bottom));
        if (keep) begin
          acc = use_and ? (acc & win[c][r]) : (acc | win[c][r]);
        end
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/bmo_in_if.sv =====
interface bmo_in_if import bmo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

// ===== rtl/bmo_out_if.sv =====
interface bmo_out_if import bmo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/bmo_ram.sv =====
module bmo_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

// ===== rtl/bmo_line.sv =====
module bmo_line import bmo_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [COL_W-1:0] col_i,
  input  logic             bit_i,
  output win_t             win_o
);

  logic             v1_q;
  logic [COL_W-1:0] col1_q;
  logic             bit1_q;
  logic             fv_q;
  logic [COL_W-1:0] fa_q;
  logic [1:0]       fd_q;
  win_t             win_q;

  logic [1:0] ram_rd;
  logic [1:0] rows;
  logic [1:0] wdata;

  // entry per column: [0] = row above the new pixel, [1] = two rows above
  bmo_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (col1_q),
    .wdata_i (wdata),
    .raddr_i (col_i),
    .rdata_o (ram_rd)
  );

  // a write in the cycle of our read is not in the RAM data yet
  assign rows  = (fv_q && fa_q == col1_q) ? fd_q : ram_rd;
  assign wdata = {rows[0], bit1_q};
  assign win_o = win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      fv_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      fv_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q <= col_i;
    bit1_q <= bit_i;
    fa_q   <= col1_q;
    fd_q   <= wdata;
    if (v1_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= {rows[1], rows[0], bit1_q};
    end
  end

endmodule

// ===== rtl/bmo_ofifo.sv =====
module bmo_ofifo import bmo_pkg::*; #(
  parameter int unsigned DEPTH = OFIFO_DEPTH,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  res_t             data_i,
  output logic [CNT_W-1:0] count_o,
  bmo_out_if.source        out
);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out.valid      = (cnt_q != '0);
  assign out.pixel_out  = mem_q[rd_q].pixel;
  assign out.frame_last = mem_q[rd_q].last;
  assign pop            = out.valid && out.ready;
  assign count_o        = cnt_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/binary_morph_opening_3x3_top.sv =====
// Binary 3x3 opening (erosion, then dilation) of a raster pixel stream. One item per cycle
// is taken while the result side keeps up and the block is not stepping on its own; each
// result passes the erosion and dilation windows and an 8-entry output queue. Pixel k of
// the frame comes out on the item that brings input pixel k + 2*W + 2; after the last
// input pixel, drain items (or pixel items, whose pixel is then dropped) deliver the rest,
// one each. In a frame too short to reach the first result before its input ends, the
// block steps its windows on its own, with ready low, until the first result is due. Two
// simple dual-port column stores, one for the binarized rows and one for the eroded rows,
// set the line width limit MAX_WIDTH. Writing the width or height restarts the frame.
module binary_morph_opening_3x3_top import bmo_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bmo_in_if.sink                pix_i,
  bmo_out_if.source             res_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 4);
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LAG_W = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned CNT_W = $clog2(OFIFO_DEPTH + 1);
  localparam int unsigned W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int unsigned H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  logic [PIX_W-1:0] thr_q;
  logic [W_W-1:0]   w_q, w_cfg;
  logic [H_W-1:0]   h_q, h_cfg;
  logic             dim_wr;

  logic [ROW_W-1:0] b_row_q, b_row_d, e_row_q, e_row_d, o_row_q, o_row_d;
  logic [COL_W-1:0] b_col_q, b_col_d, e_col_q, e_col_d, o_col_q, o_col_d;
  logic [LAG_W-1:0] lag_q, lag_d;

  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [LAG_W-1:0] e_start, o_start;
  logic             input_done, e_on, o_on, warm, last;
  logic [2:0]       inflight;
  logic [CNT_W-1:0] fifo_cnt;
  logic             credit_ok, accept, tick, bin;

  tick_t            tk, p1_q, p2_q, p3_q, p4_q;
  logic [COL_W-1:0] ec1_q, ec2_q;
  win_t             bin_win, ero_win;
  logic             eroded, opened;
  res_t             res;

  // configuration, dimensions clamped to 1..MAX
  always_comb begin
    if (cfg_data_i == '0) begin
      w_cfg = W_W'(1);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      w_cfg = W_W'(MAX_WIDTH);
    end else begin
      w_cfg = W_W'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_cfg = H_W'(1);
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      h_cfg = H_W'(MAX_HEIGHT);
    end else begin
      h_cfg = H_W'(cfg_data_i);
    end
  end

  assign dim_wr = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      w_q   <= W_W'(W_RST);
      h_q   <= H_W'(H_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[PIX_W-1:0];
        REG_WIDTH:     w_q   <= w_cfg;
        REG_HEIGHT:    h_q   <= h_cfg;
        default: ;
      endcase
    end
  end

  // front: positions of the incoming column (b), the erosion center (e) and the result (o)
  assign w_m1       = COL_W'(w_q - W_W'(1));
  assign h_m1       = ROW_W'(h_q) - ROW_W'(1);
  assign e_start    = LAG_W'(w_q) + LAG_W'(1);
  assign o_start    = LAG_W'({w_q, 1'b0}) + LAG_W'(2);
  assign input_done = (b_row_q >= ROW_W'(h_q));
  assign e_on       = (lag_q >= e_start);
  assign o_on       = (lag_q >= o_start);
  assign warm       = input_done && !o_on;
  assign last       = o_on && (o_row_q == h_m1) && (o_col_q == w_m1);

  // room in the queue for every result still in the pipeline
  assign inflight  = 3'(p1_q.valid && p1_q.emit) + 3'(p2_q.valid && p2_q.emit) +
                     3'(p3_q.valid && p3_q.emit) + 3'(p4_q.valid && p4_q.emit);
  assign credit_ok = ((CNT_W + 1)'(fifo_cnt) + (CNT_W + 1)'(inflight)) <
                     (CNT_W + 1)'(OFIFO_DEPTH);

  assign pix_i.ready = credit_ok && !warm;
  assign accept      = pix_i.valid && pix_i.ready;
  assign tick        = (warm && credit_ok) ||
                       (accept && (input_done || pix_i.mode == MODE_PIXEL));
  assign bin         = (pix_i.pixel_in > thr_q);

  always_comb begin
    tk.valid     = tick;
    tk.emit      = o_on;
    tk.last      = last;
    tk.eb.top    = (e_row_q == '0);
    tk.eb.bottom = (e_row_q >= h_m1);
    tk.eb.left   = (e_col_q == '0);
    tk.eb.right  = (e_col_q == w_m1);
    tk.ob.top    = (o_row_q == '0);
    tk.ob.bottom = (o_row_q >= h_m1);
    tk.ob.left   = (o_col_q == '0);
    tk.ob.right  = (o_col_q == w_m1);
  end

  always_comb begin
    b_row_d = b_row_q;
    b_col_d = b_col_q;
    e_row_d = e_row_q;
    e_col_d = e_col_q;
    o_row_d = o_row_q;
    o_col_d = o_col_q;
    lag_d   = lag_q;
    if (dim_wr || (tick && last)) begin
      b_row_d = '0;
      b_col_d = '0;
      e_row_d = '0;
      e_col_d = '0;
      o_row_d = '0;
      o_col_d = '0;
      lag_d   = '0;
    end else if (tick) begin
      if (b_col_q == w_m1) begin
        b_col_d = '0;
        b_row_d = b_row_q + ROW_W'(1);
      end else begin
        b_col_d = b_col_q + COL_W'(1);
      end
      if (e_on) begin
        if (e_col_q == w_m1) begin
          e_col_d = '0;
          e_row_d = e_row_q + ROW_W'(1);
        end else begin
          e_col_d = e_col_q + COL_W'(1);
        end
      end
      if (o_on) begin
        if (o_col_q == w_m1) begin
          o_col_d = '0;
          o_row_d = o_row_q + ROW_W'(1);
        end else begin
          o_col_d = o_col_q + COL_W'(1);
        end
      end else begin
        lag_d = lag_q + LAG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_row_q <= '0;
      b_col_q <= '0;
      e_row_q <= '0;
      e_col_q <= '0;
      o_row_q <= '0;
      o_col_q <= '0;
      lag_q   <= '0;
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= '0;
      p4_q    <= '0;
    end else begin
      b_row_q <= b_row_d;
      b_col_q <= b_col_d;
      e_row_q <= e_row_d;
      e_col_q <= e_col_d;
      o_row_q <= o_row_d;
      o_col_q <= o_col_d;
      lag_q   <= lag_d;
      p1_q    <= tk;
      p2_q    <= p1_q;
      p3_q    <= p2_q;
      p4_q    <= p3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ec1_q <= e_col_q;
    ec2_q <= ec1_q;
  end

  // binarized rows -> erosion window, in step with p2_q
  bmo_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_bin_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tick),
    .col_i   (b_col_q),
    .bit_i   (bin),
    .win_o   (bin_win)
  );

  assign eroded = win_reduce(bin_win, p2_q.eb, 1'b1);

  // eroded rows -> dilation window
  bmo_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ero_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_q.valid),
    .col_i   (ec2_q),
    .bit_i   (eroded),
    .win_o   (ero_win)
  );

  assign opened    = win_reduce(ero_win, p4_q.ob, 1'b0);
  assign res.pixel = opened ? PIX_FG : PIX_BG;
  assign res.last  = p4_q.last;

  bmo_ofifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (p4_q.valid && p4_q.emit),
    .data_i  (res),
    .count_o (fifo_cnt),
    .out     (res_o)
  );

endmodule
